[hw/rtl/bhpq_pkg.sv]
// Shared types and codes for the binary heap priority queue.
// No dependencies; compile first.
package bhpq_pkg;

   localparam int VALUE_W = 32;
   localparam int ITEM_COUNT_W = 10;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [ITEM_COUNT_W-1:0] item_count_type;

   typedef enum logic [0:0] {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      ST_PUSHED = 2'd0,
      ST_POPPED = 2'd1,
      ST_FULL   = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

endpackage

[hw/rtl/bhpq_if.sv]
// Request and response channel interfaces (valid/ready) of the heap queue.
// Depends on bhpq_pkg.
interface bhpq_req_if;
   import bhpq_pkg::*;

   logic        valid;
   logic        ready;
   command_type command;
   value_type   value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface bhpq_rsp_if;
   import bhpq_pkg::*;

   logic           valid;
   logic           ready;
   value_type      popped_value;
   status_type     status;
   item_count_type item_count;
   logic           now_empty;

   modport source (output valid, output popped_value, output status, output item_count,
                   output now_empty, input ready);
   modport sink   (input valid, input popped_value, input status, input item_count,
                   input now_empty, output ready);
endinterface

[hw/rtl/bhpq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1023,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[hw/rtl/binary_heap_priority_queue_top.sv]
// Top level of the binary heap priority queue: control sequencer and heap RAM.
// Depends on bhpq_pkg, bhpq_if (bhpq_req_if, bhpq_rsp_if) and bhpq_ram.
//
// Array binary heap of up to CAPACITY signed 32-bit values, serving the smallest
// value first when min_mode is 1 (reset) and the largest when it is 0. Each request
// beat is a push or a pop and yields exactly one response beat carrying status,
// popped value (zero unless a pop succeeded), the count after the operation (low ten
// bits) and an empty flag. Items are handled one at a time; the heap lives in a single
// RAM with one write and one read port and registered read data, and the value
// being sifted is held in a register so that only the hole moves through memory.
// Each level that a push climbs takes a parent read and a compare; each level that a
// pop sinks takes a left child read, a right child read and a compare (the two child
// reads share the one read port). The worst case is a pop that sinks to the deepest
// level. A full push or an empty pop goes straight from the start state to the finish
// state. The response sits in an output register, so the next request beat is taken
// while a response still waits. min_mode is written through csr_we/csr_wdata; the user
// must write it only while the block is idle, as the block does not enforce this. Heap
// slots are not cleared at reset: only slots below the count are ever read.
module binary_heap_priority_queue_top #(
   parameter int CAPACITY = 1023
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_wdata,
   bhpq_req_if.sink          req_ch,
   bhpq_rsp_if.source        rsp_ch
);
   import bhpq_pkg::*;

   // Slot index width and count width (count reaches CAPACITY itself).
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_UP_CHK, S_UP_CMP, S_POP_LAST, S_POP_CUR,
      S_DN_CHK, S_DN_RDR, S_DN_CMP, S_FINISH
   } state_type;

   // a sits strictly above b under the current mode
   function automatic logic beats(input logic min_sel, input value_type a,
                                  input value_type b);
      beats = min_sel ? (a < b) : (a > b);
   endfunction

   state_type      state_ff, state_in;
   logic           min_mode_ff, min_mode_in;
   logic [CW-1:0]  count_ff, count_in;
   command_type    cmd_ff, cmd_in;
   value_type      val_ff, val_in;
   value_type      cur_ff, cur_in;
   value_type      lv_ff, lv_in;
   value_type      popped_ff, popped_in;
   logic [AW-1:0]  pos_ff, pos_in;
   logic [AW-1:0]  par_ff, par_in;
   logic           rvalid_ff, rvalid_in;
   status_type     status_ff, status_in;

   logic           rsp_valid_ff, rsp_valid_in;
   value_type      out_value_ff, out_value_in;
   status_type     out_status_ff, out_status_in;
   item_count_type out_count_ff, out_count_in;
   logic           out_empty_ff, out_empty_in;

   // heap RAM port
   logic           ram_we;
   logic [AW-1:0]  ram_waddr;
   value_type      ram_wdata;
   logic           ram_re;
   logic [AW-1:0]  ram_raddr;
   logic [VALUE_W-1:0] ram_rdata_raw;
   value_type      ram_rdata;

   // index arithmetic
   logic [CW:0]    pos_ext, left_idx, right_idx, count_ext;
   logic [AW-1:0]  parent_idx;
   logic           pick_right;
   value_type      child_val;
   logic [AW-1:0]  child_idx;
   logic [CW+ITEM_COUNT_W-1:0] count_wide;

   bhpq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata_raw)
   );

   assign ram_rdata = value_type'(ram_rdata_raw);

   // children of the hole at 2i+1 and 2i+2, parent at (i-1)/2
   assign pos_ext    = {{(CW + 1 - AW){1'b0}}, pos_ff};
   assign left_idx   = (pos_ext << 1) + (CW + 1)'(1);
   assign right_idx  = left_idx + (CW + 1)'(1);
   assign count_ext  = {1'b0, count_ff};
   assign parent_idx = AW'((pos_ff - AW'(1)) >> 1);

   // Min mode takes the right child on a tie, max mode the left one.
   assign pick_right = rvalid_ff && (min_mode_ff ^ (lv_ff < ram_rdata));
   assign child_val  = pick_right ? ram_rdata : lv_ff;
   assign child_idx  = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

   assign count_wide = {{ITEM_COUNT_W{1'b0}}, count_ff};

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.popped_value = out_value_ff;
   assign rsp_ch.status       = out_status_ff;
   assign rsp_ch.item_count   = out_count_ff;
   assign rsp_ch.now_empty    = out_empty_ff;

   always_comb begin
      state_in      = state_ff;
      min_mode_in   = csr_we ? csr_wdata : min_mode_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      cur_in        = cur_ff;
      lv_in         = lv_ff;
      popped_in     = popped_ff;
      pos_in        = pos_ff;
      par_in        = par_ff;
      rvalid_in     = rvalid_ff;
      status_in     = status_ff;
      // drop the response once the sink takes it
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      out_empty_in  = out_empty_ff;
      ram_we        = 1'b0;
      ram_waddr     = pos_ff;
      ram_wdata     = cur_ff;
      ram_re        = 1'b0;
      ram_raddr     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in   = req_ch.command;
               val_in   = req_ch.value;
               state_in = S_START;
            end
         end
         S_START: begin
            if (cmd_ff == CMD_PUSH) begin
               if (count_ff >= CW'(CAPACITY)) begin
                  status_in = ST_FULL;
                  state_in  = S_FINISH;
               end else begin
                  // open the hole at the next free slot
                  pos_in    = count_ff[AW-1:0];
                  cur_in    = val_ff;
                  count_in  = count_ff + CW'(1);
                  status_in = ST_PUSHED;
                  state_in  = S_UP_CHK;
               end
            end else begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
                  state_in  = S_FINISH;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = '0;
                  count_in  = count_ff - CW'(1);
                  status_in = ST_POPPED;
                  state_in  = S_POP_LAST;
               end
            end
         end
         S_UP_CHK: begin
            if (pos_ff == '0) begin
               ram_we   = 1'b1;
               state_in = S_FINISH;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = parent_idx;
               par_in    = parent_idx;
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            ram_we = 1'b1;
            if (beats(min_mode_ff, cur_ff, ram_rdata)) begin
               // move the parent down into the hole
               ram_wdata = ram_rdata;
               pos_in    = par_ff;
               state_in  = S_UP_CHK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_POP_LAST: begin
            popped_in = ram_rdata;
            ram_re    = 1'b1;
            ram_raddr = count_ff[AW-1:0];
            state_in  = S_POP_CUR;
         end
         S_POP_CUR: begin
            cur_in   = ram_rdata;
            pos_in   = '0;
            state_in = S_DN_CHK;
         end
         S_DN_CHK: begin
            if (left_idx >= count_ext) begin
               ram_we   = 1'b1;
               state_in = S_FINISH;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = left_idx[AW-1:0];
               state_in  = S_DN_RDR;
            end
         end
         S_DN_RDR: begin
            lv_in     = ram_rdata;
            rvalid_in = (right_idx < count_ext);
            if (right_idx < count_ext) begin
               ram_re    = 1'b1;
               ram_raddr = right_idx[AW-1:0];
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            ram_we = 1'b1;
            if (beats(min_mode_ff, child_val, cur_ff)) begin
               // lift the chosen child into the hole
               ram_wdata = child_val;
               pos_in    = child_idx;
               state_in  = S_DN_CHK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               out_value_in  = (status_ff == ST_POPPED) ? popped_ff : '0;
               out_status_in = status_ff;
               out_count_in  = count_wide[ITEM_COUNT_W-1:0];
               out_empty_in  = (count_ff == '0);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         min_mode_ff  <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_mode_ff  <= min_mode_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      lv_ff         <= lv_in;
      popped_ff     <= popped_in;
      pos_ff        <= pos_in;
      par_ff        <= par_in;
      rvalid_ff     <= rvalid_in;
      status_ff     <= status_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
      out_empty_ff  <= out_empty_in;
   end

endmodule
